// ----- src/gb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types, register codes and widths of the 3x3 rgb gaussian blur.
// ----------------------------------------------------------------------------
package gb3_pkg;

    // channel and pixel widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int SUM4_W   = CH_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int POS_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_W_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_CORNER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

    // reset values
    localparam int W_CENTER_RST = 10587;
    localparam int W_EDGE_RST   = 7877;
    localparam int W_CORNER_RST = 5860;
    localparam int WIDTH_RST    = 128;
    localparam int HEIGHT_RST   = 128;

    // parameter defaults
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    // queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int Q_CNT_W = QPTR_W + 1;

    // per-channel tap sums of one window
    typedef struct packed {
        logic [SUM4_W-1:0] corner;
        logic [SUM4_W-1:0] side;
        logic [CH_W-1:0]   center;
    } t_chan_sums;

    typedef struct packed {
        t_chan_sums [2:0] ch;
        logic             done;
    } t_job;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

// ----- src/gb3_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_queue
// Small fifo of window jobs between the line-store front and the mac back.
// ----------------------------------------------------------------------------
module gb3_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gb3_pkg::t_job  i_push_job,
    input  logic           i_pop,
    output gb3_pkg::t_job  o_pop_job,
    output gb3_pkg::t_q_stat o_stat
);

    gb3_pkg::t_job                    r_mem [gb3_pkg::QDEPTH];
    logic [gb3_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [gb3_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [gb3_pkg::Q_CNT_W-1:0]      r_count;
    logic                             w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    assign o_pop_job    = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

// ----- src/gb3_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_front
// Accepts pixels and drain ticks, keeps frame position, line stores and the
// 3x3 window, and queues per-channel tap sums for each output pixel.
// ----------------------------------------------------------------------------
module gb3_front #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gb3_pkg::CH_W-1:0]      i_chan_blue,
    input  logic [gb3_pkg::CH_W-1:0]      i_chan_green,
    input  logic [gb3_pkg::CH_W-1:0]      i_chan_red,
    input  logic                          i_flush_tick,
    input  logic [gb3_pkg::WIDTH_W-1:0]   i_width,
    input  logic [gb3_pkg::POS_W-1:0]     i_total,
    input  logic                          i_restart,
    input  logic                          i_hold,
    input  gb3_pkg::t_q_stat              i_qstat,
    output logic                          o_push,
    output gb3_pkg::t_job                 o_job
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef logic [8:0][gb3_pkg::PIX_W-1:0] t_win;
    typedef logic [2:0][gb3_pkg::PIX_W-1:0] t_col;

    function automatic gb3_pkg::t_chan_sums chan_sums(t_win w, int ch);
        gb3_pkg::t_chan_sums s;
        s.corner = gb3_pkg::SUM4_W'(w[0][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[2][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[6][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[8][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W]);
        s.side   = gb3_pkg::SUM4_W'(w[1][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[3][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[5][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W])
                 + gb3_pkg::SUM4_W'(w[7][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W]);
        s.center = w[4][ch*gb3_pkg::CH_W +: gb3_pkg::CH_W];
        return s;
    endfunction

    // line stores
    logic [gb3_pkg::PIX_W-1:0] r_store_up  [MAX_WIDTH];
    logic [gb3_pkg::PIX_W-1:0] r_store_mid [MAX_WIDTH];

    // frame position
    logic [gb3_pkg::WIDTH_W-1:0] r_col;
    logic [1:0]                  r_row;
    logic [gb3_pkg::POS_W-1:0]   r_pos;
    logic [gb3_pkg::POS_W-1:0]   r_emit;

    // second stage
    logic                      r_f1_valid;
    logic [AW-1:0]             r_f1_addr;
    logic [gb3_pkg::PIX_W-1:0] r_f1_pix;
    logic                      r_f1_up_en;
    logic                      r_f1_mid_en;
    logic                      r_f1_col0;
    logic                      r_f1_emit;
    logic                      r_f1_done;
    logic [gb3_pkg::PIX_W-1:0] r_up_rd;
    logic [gb3_pkg::PIX_W-1:0] r_mid_rd;
    logic                      r_byp;
    logic [gb3_pkg::PIX_W-1:0] r_byp_up;
    logic [gb3_pkg::PIX_W-1:0] r_byp_mid;
    t_win                      r_win;

    logic                        w_room;
    logic                        w_accept;
    logic                        w_drain;
    logic                        w_take;
    logic                        w_col0;
    logic                        w_emit;
    logic                        w_done;
    logic [AW-1:0]               w_addr;
    logic [gb3_pkg::WIDTH_W-1:0] n_col;
    t_col                        w_colpix;
    t_win                        n_win;
    t_win                        w_calc;

    assign w_room = ((gb3_pkg::Q_CNT_W + 1)'(i_qstat.count)
                     + (gb3_pkg::Q_CNT_W + 1)'(r_f1_valid))
                    < (gb3_pkg::Q_CNT_W + 1)'(gb3_pkg::QDEPTH);
    assign o_ready  = w_room && !i_hold;
    assign w_accept = i_valid && o_ready;

    // once every pixel is in, each item drains; a tick before that is dropped
    assign w_drain = (r_pos >= i_total);
    assign w_take  = w_accept && (w_drain || !i_flush_tick);
    assign w_col0  = (r_col == '0);
    assign w_emit  = w_col0 ? (r_row >= 2'd2) : (r_row >= 2'd1);
    assign w_done  = w_emit && ((r_emit + 1'b1) >= i_total);
    assign w_addr  = AW'(r_col);
    assign n_col   = r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pos  <= '0;
            r_emit <= '0;
        end else if (w_take) begin
            if (w_done) begin
                r_col  <= '0;
                r_row  <= '0;
                r_pos  <= '0;
                r_emit <= '0;
            end else begin
                if (n_col >= i_width) begin
                    r_col <= '0;
                    if (r_row != 2'd2) begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= n_col;
                end
                r_pos  <= r_pos + 1'b1;
                r_emit <= r_emit + gb3_pkg::POS_W'(w_emit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            r_f1_valid <= w_take;
            if (w_take) begin
                // the write of the item ahead lands in this same cycle
                r_byp <= r_f1_valid && (r_f1_addr == w_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_f1_addr   <= w_addr;
            r_f1_pix    <= w_drain ? '0 : {i_chan_red, i_chan_green, i_chan_blue};
            r_f1_up_en  <= (r_row >= 2'd2);
            r_f1_mid_en <= (r_row >= 2'd1);
            r_f1_col0   <= w_col0;
            r_f1_emit   <= w_emit;
            r_f1_done   <= w_done;
            r_up_rd     <= r_store_up[w_addr];
            r_mid_rd    <= r_store_mid[w_addr];
            r_byp_up    <= w_colpix[1];
            r_byp_mid   <= w_colpix[2];
        end
        if (r_f1_valid) begin
            r_store_up[r_f1_addr]  <= w_colpix[1];
            r_store_mid[r_f1_addr] <= w_colpix[2];
            r_win                  <= n_win;
        end
    end

    // rows above the frame read as zero
    always_comb begin
        w_colpix[0] = r_f1_up_en ? (r_byp ? r_byp_up : r_up_rd) : '0;
        w_colpix[1] = r_f1_mid_en ? (r_byp ? r_byp_mid : r_mid_rd) : '0;
        w_colpix[2] = r_f1_pix;
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (r_f1_col0) begin
                // finishing the previous row: right column is outside the frame
                w_calc[r*3 + 0] = r_win[r*3 + 1];
                w_calc[r*3 + 1] = r_win[r*3 + 2];
                w_calc[r*3 + 2] = '0;
                n_win[r*3 + 0]  = '0;
                n_win[r*3 + 1]  = '0;
                n_win[r*3 + 2]  = w_colpix[r];
            end else begin
                n_win[r*3 + 0]  = r_win[r*3 + 1];
                n_win[r*3 + 1]  = r_win[r*3 + 2];
                n_win[r*3 + 2]  = w_colpix[r];
                w_calc[r*3 + 0] = r_win[r*3 + 1];
                w_calc[r*3 + 1] = r_win[r*3 + 2];
                w_calc[r*3 + 2] = w_colpix[r];
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            o_job.ch[ch] = chan_sums(w_calc, ch);
        end
        o_job.done = r_f1_done;
    end

    assign o_push = r_f1_valid && r_f1_emit;

endmodule

// ----- src/gb3_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_back
// Weights the queued tap sums, truncates, saturates and holds the result.
// ----------------------------------------------------------------------------
module gb3_back #(
    parameter int WEIGHT_BITS = gb3_pkg::WEIGHT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gb3_pkg::t_q_stat         i_qstat,
    output logic                     o_pop,
    input  gb3_pkg::t_job            i_job,
    input  logic [WEIGHT_BITS-1:0]   i_w_center,
    input  logic [WEIGHT_BITS-1:0]   i_w_edge,
    input  logic [WEIGHT_BITS-1:0]   i_w_corner,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [gb3_pkg::CH_W-1:0] o_out_blue,
    output logic [gb3_pkg::CH_W-1:0] o_out_green,
    output logic [gb3_pkg::CH_W-1:0] o_out_red,
    output logic                     o_frame_done
);

    localparam int PS_W  = gb3_pkg::SUM4_W + WEIGHT_BITS;
    localparam int PM_W  = gb3_pkg::CH_W + WEIGHT_BITS;
    localparam int SUM_W = PS_W + 2;
    localparam int SH_W  = SUM_W - WEIGHT_BITS;

    logic                       r_b1_valid;
    logic                       r_b1_done;
    logic [2:0][PS_W-1:0]       r_p_corner;
    logic [2:0][PS_W-1:0]       r_p_side;
    logic [2:0][PM_W-1:0]       r_p_center;
    logic                       r_o_valid;
    logic [2:0][gb3_pkg::CH_W-1:0] r_o_pix;
    logic                       r_o_done;

    logic                          w_en;
    logic [2:0][SUM_W-1:0]         w_sum;
    logic [2:0][SH_W-1:0]          w_shr;
    logic [2:0][gb3_pkg::CH_W-1:0] w_sat;

    // whole pipe moves together when the output slot can take a value
    assign w_en  = !r_o_valid || i_ready;
    assign o_pop = w_en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_en) begin
            r_b1_valid <= !i_qstat.empty;
            r_o_valid  <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p_corner[ch] <= PS_W'(i_job.ch[ch].corner) * PS_W'(i_w_corner);
                r_p_side[ch]   <= PS_W'(i_job.ch[ch].side) * PS_W'(i_w_edge);
                r_p_center[ch] <= PM_W'(i_job.ch[ch].center) * PM_W'(i_w_center);
            end
            r_b1_done <= i_job.done;
        end
        if (w_en && r_b1_valid) begin
            r_o_pix  <= w_sat;
            r_o_done <= r_b1_done;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_sum[ch] = SUM_W'(r_p_corner[ch]) + SUM_W'(r_p_side[ch])
                      + SUM_W'(r_p_center[ch]);
            w_shr[ch] = w_sum[ch][SUM_W-1:WEIGHT_BITS];
            w_sat[ch] = (w_shr[ch][SH_W-1:gb3_pkg::CH_W] != '0)
                      ? {gb3_pkg::CH_W{1'b1}} : w_shr[ch][gb3_pkg::CH_W-1:0];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_blue   = r_o_pix[0];
    assign o_out_green  = r_o_pix[1];
    assign o_out_red    = r_o_pix[2];
    assign o_frame_done = r_o_done;

endmodule

// ----- src/gaussian_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb
// Streaming 3x3 gaussian blur of raster-order 24-bit rgb pixels.
// ----------------------------------------------------------------------------
// Takes one pixel (or drain tick) per clock when ready and gives one blurred
// pixel per clock once the window is primed, unless stalled; results lag the
// stream by one row plus one pixel, so after the last pixel of a frame send
// frame_width+1 drain ticks. An item passes through four register stages:
// line-store read, window and tap sums, one multiplier per tap class and
// channel, then add, truncate and saturate into the output register. A small
// queue between the line-store front and the multiplier back keeps input
// flowing while the output is stalled. The line stores are MAX_WIDTH-entry
// memories with one read and one write per cycle; they need no clearing pass
// since rows above the frame are masked by the row position. A config
// transfer blocks input for the following cycle while frame size settles.
// The user must write config only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH   = gb3_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = gb3_pkg::WEIGHT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gb3_pkg::CH_W-1:0]        i_chan_blue,
    input  logic [gb3_pkg::CH_W-1:0]        i_chan_green,
    input  logic [gb3_pkg::CH_W-1:0]        i_chan_red,
    input  logic                            i_flush_tick,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gb3_pkg::CH_W-1:0]        o_out_blue,
    output logic [gb3_pkg::CH_W-1:0]        o_out_green,
    output logic [gb3_pkg::CH_W-1:0]        o_out_red,
    output logic                            o_frame_done,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WidthRst = (gb3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                               : gb3_pkg::WIDTH_RST;

    logic [WEIGHT_BITS-1:0]        r_w_center;
    logic [WEIGHT_BITS-1:0]        r_w_edge;
    logic [WEIGHT_BITS-1:0]        r_w_corner;
    logic [gb3_pkg::WIDTH_W-1:0]   r_width;
    logic [gb3_pkg::HEIGHT_W-1:0]  r_height;
    logic [gb3_pkg::POS_W-1:0]     r_total;
    logic                          r_settle;

    logic                          w_cfg_xfer;
    logic                          w_geom_xfer;
    logic [gb3_pkg::WIDTH_W-1:0]   w_wv;
    logic [gb3_pkg::HEIGHT_W-1:0]  w_hv;
    logic                          w_push;
    logic                          w_pop;
    gb3_pkg::t_job                 w_push_job;
    gb3_pkg::t_job                 w_pop_job;
    gb3_pkg::t_q_stat              w_qstat;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_geom_xfer = w_cfg_xfer && ((i_cfg_index == gb3_pkg::CFG_WIDTH)
                                        || (i_cfg_index == gb3_pkg::CFG_HEIGHT));

    // frame size clamps
    always_comb begin
        w_wv = i_cfg_data[gb3_pkg::WIDTH_W-1:0];
        if (w_wv == '0) begin
            w_wv = gb3_pkg::WIDTH_W'(1);
        end else if (32'(w_wv) > 32'(MAX_WIDTH)) begin
            w_wv = gb3_pkg::WIDTH_W'(MAX_WIDTH);
        end
        w_hv = i_cfg_data[gb3_pkg::HEIGHT_W-1:0];
        if (w_hv == '0) begin
            w_hv = gb3_pkg::HEIGHT_W'(1);
        end else if (w_hv > gb3_pkg::HEIGHT_MAX) begin
            w_hv = gb3_pkg::HEIGHT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_center <= WEIGHT_BITS'(gb3_pkg::W_CENTER_RST);
            r_w_edge   <= WEIGHT_BITS'(gb3_pkg::W_EDGE_RST);
            r_w_corner <= WEIGHT_BITS'(gb3_pkg::W_CORNER_RST);
            r_width    <= gb3_pkg::WIDTH_W'(WidthRst);
            r_height   <= gb3_pkg::HEIGHT_W'(gb3_pkg::HEIGHT_RST);
            r_settle   <= 1'b1;
        end else begin
            r_settle <= w_cfg_xfer;
            if (w_cfg_xfer) begin
                case (i_cfg_index)
                    gb3_pkg::CFG_W_CENTER: begin
                        r_w_center <= WEIGHT_BITS'(i_cfg_data);
                    end
                    gb3_pkg::CFG_W_EDGE: begin
                        r_w_edge <= WEIGHT_BITS'(i_cfg_data);
                    end
                    gb3_pkg::CFG_W_CORNER: begin
                        r_w_corner <= WEIGHT_BITS'(i_cfg_data);
                    end
                    gb3_pkg::CFG_WIDTH: begin
                        r_width <= w_wv;
                    end
                    gb3_pkg::CFG_HEIGHT: begin
                        r_height <= w_hv;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // pixels per frame, registered from the size registers
    always_ff @(posedge i_clk) begin
        r_total <= gb3_pkg::POS_W'(r_width) * gb3_pkg::POS_W'(r_height);
    end

    gb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_chan_blue  (i_chan_blue),
        .i_chan_green (i_chan_green),
        .i_chan_red   (i_chan_red),
        .i_flush_tick (i_flush_tick),
        .i_width      (r_width),
        .i_total      (r_total),
        .i_restart    (w_geom_xfer),
        .i_hold       (r_settle),
        .i_qstat      (w_qstat),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    gb3_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_stat     (w_qstat)
    );

    gb3_back #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .i_job        (w_pop_job),
        .i_w_center   (r_w_center),
        .i_w_edge     (r_w_edge),
        .i_w_corner   (r_w_corner),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red),
        .o_frame_done (o_frame_done)
    );

    // a push never lands on a full queue
    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_qstat.count != gb3_pkg::Q_CNT_W'(gb3_pkg::QDEPTH)))
        else $error("push into full queue");

    // input is offered only with queue room to spare
    ap_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_qstat.count < gb3_pkg::Q_CNT_W'(gb3_pkg::QDEPTH)))
        else $error("ready with full queue");

    // frame total must settle before the next pixel transfer
    ap_geom_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_geom_xfer |=> !o_ready)
        else $error("input taken before frame size settled");

    // nothing is popped from an empty queue
    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

endmodule
